@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DSQF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property violated");

// Consequent checked in the cycle after the antecedent.
`define DSQF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

@@ rtl/core/dsqf_pkg.sv @@
// ----------------------------------------------------------------------------
// Sensor fusion package
// Field widths, register codes, controller states and control structures.
// ----------------------------------------------------------------------------
package dsqf_pkg;

	localparam int QUAL_W   = 7;
	localparam int HEAD_W   = 16;
	localparam int VEL_W    = 27;
	localparam int WT_W     = 8;
	localparam int HPROD_W  = HEAD_W + WT_W;
	localparam int HSUM_W   = HPROD_W + 1;

	localparam logic [QUAL_W-1:0] MIN_QUALITY_RST  = 7'd90;
	localparam logic [QUAL_W-1:0] SYNC_QUALITY_RST = 7'd99;

	// Milliseconds to seconds scale for the velocity numerator.
	localparam logic signed [10:0] VEL_SCALE = 11'sd1000;

	typedef enum logic {
		REG_MIN_QUALITY  = 1'b0,
		REG_SYNC_QUALITY = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		DIV_X,
		DIV_Y,
		DIV_H,
		DIV_VX,
		DIV_VY
	} div_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_DIV_GO,
		S_DIV_WAIT,
		S_VEL,
		S_VCHK,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic     load;
		logic     mul;
		logic     sum;
		logic     vel;
		logic     div_start;
		div_sel_t div_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic wt_zero;
		logic dt_zero;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/dsqf_div.sv @@
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsqf_div #(
	parameter int N = 26,
	parameter int D = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] num,
	input  logic [D-1:0] den,
	output logic [N-1:0] quo,
	output logic         done
);

	localparam int CNT_W = $clog2(N + 1);

	logic [N-1:0]     quo_q;
	logic [D-1:0]     rem_q;
	logic [D-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D:0]       shifted;
	logic [D:0]       trial;
	logic             qbit;

	always_comb begin
		shifted = {rem_q, quo_q[N-1]};
		trial   = shifted - {1'b0, den_q};
		qbit    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], qbit};
			rem_q <= qbit ? trial[D-1:0] : shifted[D-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(N);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

@@ rtl/core/dsqf_datapath.sv @@
// ----------------------------------------------------------------------------
// Sensor fusion datapath
// Weights, products, sums, shared divider, velocity terms and output register.
// ----------------------------------------------------------------------------
module dsqf_datapath #(
	parameter int POS_BITS  = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dsqf_pkg::dp_cmd_t            cmd,
	output dsqf_pkg::dp_status_t         status,
	input  logic                         cfg_wr,
	input  logic                         cfg_index,
	input  logic [dsqf_pkg::QUAL_W-1:0]  cfg_data,
	input  logic signed [POS_BITS-1:0]   left_x,
	input  logic signed [POS_BITS-1:0]   left_y,
	input  logic [dsqf_pkg::HEAD_W-1:0]  left_heading,
	input  logic [dsqf_pkg::QUAL_W-1:0]  left_quality,
	input  logic signed [POS_BITS-1:0]   right_x,
	input  logic signed [POS_BITS-1:0]   right_y,
	input  logic [dsqf_pkg::HEAD_W-1:0]  right_heading,
	input  logic [dsqf_pkg::QUAL_W-1:0]  right_quality,
	input  logic [TIME_BITS-1:0]         reading_time,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic signed [POS_BITS-1:0]   fused_x,
	output logic signed [POS_BITS-1:0]   fused_y,
	output logic [dsqf_pkg::HEAD_W-1:0]  fused_heading,
	output logic signed [dsqf_pkg::VEL_W-1:0] vel_x,
	output logic signed [dsqf_pkg::VEL_W-1:0] vel_y,
	output logic [dsqf_pkg::WT_W-1:0]    total_weight,
	output logic [TIME_BITS-1:0]         sample_time,
	output logic                         sync_heading
);

	import dsqf_pkg::*;

	localparam int PPROD_W = POS_BITS + 8;
	localparam int PSUM_W  = POS_BITS + 9;
	localparam int DIFF_W  = POS_BITS + 1;
	localparam int VN_W    = POS_BITS + 11;
	localparam int DIV_N   = (POS_BITS + 10 > HSUM_W) ? POS_BITS + 10 : HSUM_W;

	// Configuration registers
	logic [QUAL_W-1:0] min_quality_q;
	logic [QUAL_W-1:0] sync_quality_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_quality_q  <= MIN_QUALITY_RST;
			sync_quality_q <= SYNC_QUALITY_RST;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_QUALITY:  min_quality_q  <= cfg_data;
				REG_SYNC_QUALITY: sync_quality_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Weights and sync flag from the incoming reading
	logic [WT_W-1:0] wl_in, wr_in;
	logic            sync_in;

	always_comb begin
		wl_in   = (left_quality >= min_quality_q) ?
			WT_W'(left_quality - min_quality_q) : '0;
		wr_in   = (right_quality >= min_quality_q) ?
			WT_W'(right_quality - min_quality_q) : '0;
		sync_in = (left_quality >= sync_quality_q) && (right_quality >= sync_quality_q);
	end

	logic signed [POS_BITS-1:0] lx_q, ly_q, rx_q, ry_q;
	logic [HEAD_W-1:0]          lh_q, rh_q;
	logic [TIME_BITS-1:0]       t_q;
	logic [WT_W-1:0]            wl_q, wr_q, wt_q;
	logic                       sync_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lx_q   <= left_x;
			ly_q   <= left_y;
			lh_q   <= left_heading;
			rx_q   <= right_x;
			ry_q   <= right_y;
			rh_q   <= right_heading;
			t_q    <= reading_time;
			wl_q   <= wl_in;
			wr_q   <= wr_in;
			wt_q   <= wl_in + wr_in;
			sync_q <= sync_in;
		end
	end

	// Products
	logic signed [PPROD_W-1:0] plx_q, prx_q, ply_q, pry_q;
	logic [HPROD_W-1:0]        phl_q, phr_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			plx_q <= PPROD_W'(lx_q * $signed({1'b0, wl_q}));
			prx_q <= PPROD_W'(rx_q * $signed({1'b0, wr_q}));
			ply_q <= PPROD_W'(ly_q * $signed({1'b0, wl_q}));
			pry_q <= PPROD_W'(ry_q * $signed({1'b0, wr_q}));
			phl_q <= HPROD_W'(lh_q * wl_q);
			phr_q <= HPROD_W'(rh_q * wr_q);
		end
	end

	// Weighted sums
	logic signed [PSUM_W-1:0] nx_q, ny_q;
	logic [HSUM_W-1:0]        nh_q;

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			nx_q <= PSUM_W'(plx_q) + PSUM_W'(prx_q);
			ny_q <= PSUM_W'(ply_q) + PSUM_W'(pry_q);
			nh_q <= HSUM_W'(phl_q) + HSUM_W'(phr_q);
		end
	end

	// Kept state of the last result
	logic signed [POS_BITS-1:0] last_x_q, last_y_q;
	logic [TIME_BITS-1:0]       last_time_q;

	// Fused values and velocity numerators
	logic signed [POS_BITS-1:0] fx_q, fy_q;
	logic [HEAD_W-1:0]          fh_q;
	logic signed [VEL_W-1:0]    vx_q, vy_q;
	logic signed [VN_W-1:0]     vnx_q, vny_q;
	logic [TIME_BITS-1:0]       dt_q;
	logic signed [DIFF_W-1:0]   dx, dy;

	always_comb begin
		dx = DIFF_W'(fx_q) - DIFF_W'(last_x_q);
		dy = DIFF_W'(fy_q) - DIFF_W'(last_y_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.vel) begin
			vnx_q <= VN_W'(dx * VEL_SCALE);
			vny_q <= VN_W'(dy * VEL_SCALE);
			dt_q  <= t_q - last_time_q;
		end
	end

	// Shared divider: sign handled around an unsigned core
	logic signed [DIV_N:0]  num_s;
	logic [DIV_N-1:0]       num_mag;
	logic [TIME_BITS-1:0]   den;
	logic [DIV_N-1:0]       quo;
	logic                   div_done;
	logic signed [DIV_N:0]  quo_s;
	div_sel_t               div_sel_q;
	logic                   div_neg_q;

	always_comb begin
		case (cmd.div_sel)
			DIV_X: begin
				num_s = (DIV_N+1)'(nx_q);
				den   = TIME_BITS'(wt_q);
			end
			DIV_Y: begin
				num_s = (DIV_N+1)'(ny_q);
				den   = TIME_BITS'(wt_q);
			end
			DIV_H: begin
				num_s = $signed((DIV_N+1)'(nh_q));
				den   = TIME_BITS'(wt_q);
			end
			DIV_VX: begin
				num_s = (DIV_N+1)'(vnx_q);
				den   = dt_q;
			end
			DIV_VY: begin
				num_s = (DIV_N+1)'(vny_q);
				den   = dt_q;
			end
			default: begin
				num_s = '0;
				den   = TIME_BITS'(wt_q);
			end
		endcase
		num_mag = num_s[DIV_N] ? DIV_N'(-num_s) : DIV_N'(num_s);
		quo_s   = div_neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	end

	dsqf_div #(
		.N(DIV_N),
		.D(TIME_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_mag),
		.den    (den),
		.quo    (quo),
		.done   (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
			div_neg_q <= num_s[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vel) begin
			// A zero time step leaves the velocities at zero.
			vx_q <= '0;
			vy_q <= '0;
		end else if (div_done) begin
			case (div_sel_q)
				DIV_X:   fx_q <= POS_BITS'(quo_s);
				DIV_Y:   fy_q <= POS_BITS'(quo_s);
				DIV_H:   fh_q <= HEAD_W'(quo);
				DIV_VX:  vx_q <= VEL_W'(quo_s);
				DIV_VY:  vy_q <= VEL_W'(quo_s);
				default: ;
			endcase
		end
	end

	// Output register and kept state
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_time_q <= '0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
			last_x_q    <= fx_q;
			last_y_q    <= fy_q;
			last_time_q <= t_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fused_x       <= fx_q;
			fused_y       <= fy_q;
			fused_heading <= fh_q;
			vel_x         <= vx_q;
			vel_y         <= vy_q;
			total_weight  <= wt_q;
			sample_time   <= t_q;
			sync_heading  <= sync_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.wt_zero  = (wt_q == '0);
		status.dt_zero  = (dt_q == '0);
		status.div_done = div_done;
		status.out_free = !out_valid_q || !out_stall;
	end

endmodule

@@ rtl/core/dsqf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sensor fusion controller
// Sequences one reading through the datapath and the shared divider.
// ----------------------------------------------------------------------------
module dsqf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output dsqf_pkg::dp_cmd_t    cmd,
	input  dsqf_pkg::dp_status_t status
);

	import dsqf_pkg::*;

	ctrl_state_t state_q, state_d;
	div_sel_t    sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= DIV_X;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		sel_d         = sel_q;
		cmd           = '0;
		cmd.div_sel   = sel_q;
		in_stall      = 1'b1;

		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				// Both weights zero: the reading is dropped without a result.
				if (status.wt_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				sel_d   = DIV_X;
				state_d = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (status.div_done) begin
					case (sel_q)
						DIV_X: begin
							sel_d   = DIV_Y;
							state_d = S_DIV_GO;
						end
						DIV_Y: begin
							sel_d   = DIV_H;
							state_d = S_DIV_GO;
						end
						DIV_H:   state_d = S_VEL;
						DIV_VX: begin
							sel_d   = DIV_VY;
							state_d = S_DIV_GO;
						end
						DIV_VY:  state_d = S_OUT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_VEL: begin
				cmd.vel = 1'b1;
				state_d = S_VCHK;
			end
			S_VCHK: begin
				if (status.dt_zero) begin
					state_d = S_OUT;
				end else begin
					sel_d   = DIV_VX;
					state_d = S_DIV_GO;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/dual_sensor_quality_fusion_top.sv @@
// ----------------------------------------------------------------------------
// Dual sensor quality fusion
// Fuses one paired left/right position reading into a weighted position,
// heading and velocity. Each sensor is weighted by its quality minus
// min_quality (zero below the threshold); a reading with zero total weight is
// consumed and produces no result transaction. The three weighted averages and
// the two velocities (position change times 1000 over the wrapped millisecond
// delta, zero when no time has passed) are worked out one after another on a
// single iterative divider, DIV_N = max(POS_BITS + 10, 25) bits wide, that
// yields one quotient bit per cycle. A zero time delta skips the two velocity
// divisions and a zero-weight reading skips all of them. The block takes one
// reading at a time; a finished result waits in the output register, so a new
// reading is accepted and processed while the previous result is still
// stalled.
// Configuration writes are always accepted and must only be made while idle.
// ----------------------------------------------------------------------------
module dual_sensor_quality_fusion_top #(
	parameter int POS_BITS  = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [dsqf_pkg::QUAL_W-1:0]       cfg_data,

	// Input reading channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [POS_BITS-1:0]        left_x,
	input  logic signed [POS_BITS-1:0]        left_y,
	input  logic [dsqf_pkg::HEAD_W-1:0]       left_heading,
	input  logic [dsqf_pkg::QUAL_W-1:0]       left_quality,
	input  logic signed [POS_BITS-1:0]        right_x,
	input  logic signed [POS_BITS-1:0]        right_y,
	input  logic [dsqf_pkg::HEAD_W-1:0]       right_heading,
	input  logic [dsqf_pkg::QUAL_W-1:0]       right_quality,
	input  logic [TIME_BITS-1:0]              reading_time,

	// Fused result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [POS_BITS-1:0]        fused_x,
	output logic signed [POS_BITS-1:0]        fused_y,
	output logic [dsqf_pkg::HEAD_W-1:0]       fused_heading,
	output logic signed [dsqf_pkg::VEL_W-1:0] vel_x,
	output logic signed [dsqf_pkg::VEL_W-1:0] vel_y,
	output logic [dsqf_pkg::WT_W-1:0]         total_weight,
	output logic [TIME_BITS-1:0]              sample_time,
	output logic                              sync_heading
);

	import dsqf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_wr;

	// The configuration registers are plain flops, so a write transaction
	// completes in the cycle it is presented.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// The controller owns the sequence of a reading; the datapath holds all
	// operands, the shared divider and the output register.
	dsqf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	dsqf_datapath #(
		.POS_BITS  (POS_BITS),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_wr        (cfg_wr),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.left_x        (left_x),
		.left_y        (left_y),
		.left_heading  (left_heading),
		.left_quality  (left_quality),
		.right_x       (right_x),
		.right_y       (right_y),
		.right_heading (right_heading),
		.right_quality (right_quality),
		.reading_time  (reading_time),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.fused_x       (fused_x),
		.fused_y       (fused_y),
		.fused_heading (fused_heading),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.total_weight  (total_weight),
		.sample_time   (sample_time),
		.sync_heading  (sync_heading)
	);

endmodule

@@ rtl/core/dsqf_checker.sv @@
// ----------------------------------------------------------------------------
// Sensor fusion port checker
// Port-level properties of the fusion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsqf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [dsqf_pkg::WT_W-1:0]    total_weight
);

	import dsqf_pkg::*;

	// A stalled result transaction stays offered.
	`DSQF_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid)

	// One reading at a time: the input is stalled right after an accept.
	`DSQF_ASSERT_NEXT(a_in_single, clk, arst_n, in_valid && !in_stall, in_stall)

	// Results only come from readings with a nonzero total weight.
	`DSQF_ASSERT_NOW(a_weight_nonzero, clk, arst_n, out_valid, total_weight != '0)

	// No result can appear in the cycle after a reading is accepted.
	`DSQF_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind dual_sensor_quality_fusion_top dsqf_checker u_dsqf_checker (.*);

@@ tb/dual_sensor_quality_fusion_top_tb.sv @@
// ----------------------------------------------------------------------------
// Dual sensor quality fusion testbench
// Drives paired sensor readings into the fusion block under several threshold
// settings, predicts each fused result in a scoreboard class and compares
// every result transaction field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module dual_sensor_quality_fusion_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsqf_pkg::*;

	localparam int POS_BITS           = 16;
	localparam int TIME_BITS          = 32;
	localparam int READINGS_PER_PHASE = 180;
	localparam int LAST_PHASE         = 5;
	// Long enough to cover a reading that is still being worked on after the
	// last result has been seen.
	localparam int SETTLE_CYCLES      = 200;
	localparam int LONG_HOLD_CYCLES   = 1500;
	localparam int HOLD_AFTER_RESULTS = 60;

	// One paired reading as it is offered on the input channel.
	typedef struct packed {
		logic [POS_BITS-1:0]  lx;
		logic [POS_BITS-1:0]  ly;
		logic [HEAD_W-1:0]    lh;
		logic [QUAL_W-1:0]    lq;
		logic [POS_BITS-1:0]  rx;
		logic [POS_BITS-1:0]  ry;
		logic [HEAD_W-1:0]    rh;
		logic [QUAL_W-1:0]    rq;
		logic [TIME_BITS-1:0] t;
	} reading_t;

	// One fused result as it leaves the output channel.
	typedef struct packed {
		logic [POS_BITS-1:0]  x;
		logic [POS_BITS-1:0]  y;
		logic [HEAD_W-1:0]    heading;
		logic [VEL_W-1:0]     vx;
		logic [VEL_W-1:0]     vy;
		logic [WT_W-1:0]      weight;
		logic [TIME_BITS-1:0] t;
		logic                 sync;
	} fused_t;

	// The scoreboard keeps its own copy of the thresholds and of the last
	// fused position and time, and queues the fused result that each accepted
	// reading should produce.
	class fusion_scoreboard;
		logic [QUAL_W-1:0]    min_q;
		logic [QUAL_W-1:0]    sync_q;
		logic [POS_BITS-1:0]  last_x;
		logic [POS_BITS-1:0]  last_y;
		logic [TIME_BITS-1:0] last_t;
		fused_t               fused_due[$];
		int                   errors;
		int                   results_seen;

		function new();
			min_q        = MIN_QUALITY_RST;
			sync_q       = SYNC_QUALITY_RST;
			last_x       = '0;
			last_y       = '0;
			last_t       = '0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void write_register(cfg_reg_t idx, logic [QUAL_W-1:0] value);
			if (idx == REG_MIN_QUALITY) begin
				min_q = value;
			end else begin
				sync_q = value;
			end
		endfunction

		function longint weight_of(logic [QUAL_W-1:0] q);
			return (q >= min_q) ? longint'(q) - longint'(min_q) : 0;
		endfunction

		// Position change per second; no elapsed time means no velocity.
		function longint speed(longint now_pos, logic [POS_BITS-1:0] was, longint dt);
			if (dt == 0) begin
				return 0;
			end
			return ((now_pos - longint'($signed(was))) * 1000) / dt;
		endfunction

		function void note_reading(reading_t r);
			longint               wl, wr, wt, fx, fy, fh, dt, vx, vy;
			logic [TIME_BITS-1:0] dt_raw;
			fused_t               e;
			wl = weight_of(r.lq);
			wr = weight_of(r.rq);
			wt = wl + wr;
			// A reading with no usable sensor is consumed silently.
			if (wt == 0) begin
				return;
			end
			fx = (longint'($signed(r.lx)) * wl + longint'($signed(r.rx)) * wr) / wt;
			fy = (longint'($signed(r.ly)) * wl + longint'($signed(r.ry)) * wr) / wt;
			fh = (longint'(r.lh) * wl + longint'(r.rh) * wr) / wt;
			// The delta wraps at the timestamp width.
			dt_raw = r.t - last_t;
			dt     = longint'(dt_raw);
			vx     = speed(fx, last_x, dt);
			vy     = speed(fy, last_y, dt);
			e.x       = fx[POS_BITS-1:0];
			e.y       = fy[POS_BITS-1:0];
			e.heading = fh[HEAD_W-1:0];
			e.vx      = vx[VEL_W-1:0];
			e.vy      = vy[VEL_W-1:0];
			e.weight  = wt[WT_W-1:0];
			e.t       = r.t;
			e.sync    = (r.lq >= sync_q) && (r.rq >= sync_q);
			fused_due.push_back(e);
			last_x = e.x;
			last_y = e.y;
			last_t = r.t;
		endfunction

		function string describe(fused_t f);
			return $sformatf("x=%0d y=%0d heading=%0d vel=(%0d,%0d) weight=%0d time=%0d sync=%0b",
				$signed(f.x), $signed(f.y), f.heading, $signed(f.vx), $signed(f.vy),
				f.weight, f.t, f.sync);
		endfunction

		function void check_result(fused_t got);
			fused_t e;
			string  bad;
			results_seen++;
			if (fused_due.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("fused result %0d arrived with none due: %s",
						results_seen, describe(got));
				end
				return;
			end
			e   = fused_due.pop_front();
			bad = "";
			if (got.x !== e.x) bad = {bad, " fused_x"};
			if (got.y !== e.y) bad = {bad, " fused_y"};
			if (got.heading !== e.heading) bad = {bad, " fused_heading"};
			if (got.vx !== e.vx) bad = {bad, " vel_x"};
			if (got.vy !== e.vy) bad = {bad, " vel_y"};
			if (got.weight !== e.weight) bad = {bad, " total_weight"};
			if (got.t !== e.t) bad = {bad, " sample_time"};
			if (got.sync !== e.sync) bad = {bad, " sync_heading"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("fused result %0d differs in%s", results_seen, bad);
					$display("  expected %s", describe(e));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction

		function int pending();
			return fused_due.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic                       cfg_index;
	logic [QUAL_W-1:0]          cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [POS_BITS-1:0] left_x;
	logic signed [POS_BITS-1:0] left_y;
	logic [HEAD_W-1:0]          left_heading;
	logic [QUAL_W-1:0]          left_quality;
	logic signed [POS_BITS-1:0] right_x;
	logic signed [POS_BITS-1:0] right_y;
	logic [HEAD_W-1:0]          right_heading;
	logic [QUAL_W-1:0]          right_quality;
	logic [TIME_BITS-1:0]       reading_time;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [POS_BITS-1:0] fused_x;
	logic signed [POS_BITS-1:0] fused_y;
	logic [HEAD_W-1:0]          fused_heading;
	logic signed [VEL_W-1:0]    vel_x;
	logic signed [VEL_W-1:0]    vel_y;
	logic [WT_W-1:0]            total_weight;
	logic [TIME_BITS-1:0]       sample_time;
	logic                       sync_heading;

	// Set for the closing phase, in which neither side idles.
	bit                   quiet_tail;
	// Running timestamp of the random readings.
	logic [TIME_BITS-1:0] stamp;

	fusion_scoreboard sb = new();

	dual_sensor_quality_fusion_top #(
		.POS_BITS  (POS_BITS),
		.TIME_BITS (TIME_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_x        (left_x),
		.left_y        (left_y),
		.left_heading  (left_heading),
		.left_quality  (left_quality),
		.right_x       (right_x),
		.right_y       (right_y),
		.right_heading (right_heading),
		.right_quality (right_quality),
		.reading_time  (reading_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fused_x       (fused_x),
		.fused_y       (fused_y),
		.fused_heading (fused_heading),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.total_weight  (total_weight),
		.sample_time   (sample_time),
		.sync_heading  (sync_heading)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung handshake ends the run here. The slowest correct run is well
	// under a quarter of this.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic reading_t make_reading(int lx, int ly, int lh, int lq,
			int rx, int ry, int rh, int rq, logic [TIME_BITS-1:0] t);
		reading_t r;
		r.lx = lx[POS_BITS-1:0];
		r.ly = ly[POS_BITS-1:0];
		r.lh = lh[HEAD_W-1:0];
		r.lq = lq[QUAL_W-1:0];
		r.rx = rx[POS_BITS-1:0];
		r.ry = ry[POS_BITS-1:0];
		r.rh = rh[HEAD_W-1:0];
		r.rq = rq[QUAL_W-1:0];
		r.t  = t;
		return r;
	endfunction

	// Qualities lean towards the weighted band above the current threshold,
	// with some exactly at the sync level, some below the threshold and a
	// little noise across the whole seven-bit range.
	function automatic logic [QUAL_W-1:0] pick_quality();
		int r, hi;
		r  = $urandom_range(0, 99);
		hi = (sb.min_q > 95) ? 127 : 100;
		if (r < 8) begin
			return QUAL_W'($urandom_range(0, 127));
		end
		if (r < 20 && sb.min_q > 0) begin
			return QUAL_W'($urandom_range(0, sb.min_q - 1));
		end
		if (r < 28) begin
			return sb.sync_q;
		end
		return QUAL_W'($urandom_range(sb.min_q, hi));
	endfunction

	function automatic int pick_heading();
		return ($urandom_range(0, 99) < 6) ? $urandom_range(0, 65535) : $urandom_range(0, 35999);
	endfunction

	function automatic int pick_position();
		int r;
		int edges[4] = '{-32768, 32767, 0, -1};
		r = $urandom_range(0, 99);
		if (r < 12) begin
			return edges[$urandom_range(0, 3)];
		end
		if (r < 50) begin
			return int'($urandom_range(0, 1000)) - 500;
		end
		return int'($urandom);
	endfunction

	// Time mostly moves forward by 1 to 60 milliseconds, but also stands still,
	// steps back, jumps anywhere and runs up to the wrap point.
	function automatic logic [TIME_BITS-1:0] next_stamp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			stamp = stamp;
		end else if (r < 12) begin
			stamp = stamp - $urandom_range(1, 1000);
		end else if (r < 15) begin
			stamp = $urandom;
		end else if (r < 17) begin
			stamp = 32'hFFFF_FFFF - $urandom_range(0, 20);
		end else begin
			stamp = stamp + $urandom_range(1, 60);
		end
		return stamp;
	endfunction

	function automatic reading_t random_reading();
		return make_reading(pick_position(), pick_position(), pick_heading(), pick_quality(),
			pick_position(), pick_position(), pick_heading(), pick_quality(), next_stamp());
	endfunction

	// Offers one reading and returns at the edge that accepts it. Valid is
	// left high so that a following reading can go out back to back.
	task automatic send_reading(reading_t r);
		in_valid      <= 1'b1;
		left_x        <= r.lx;
		left_y        <= r.ly;
		left_heading  <= r.lh;
		left_quality  <= r.lq;
		right_x       <= r.rx;
		right_y       <= r.ry;
		right_heading <= r.rh;
		right_quality <= r.rq;
		reading_time  <= r.t;
		do @(posedge clk); while (in_stall);
		sb.note_reading(r);
	endtask

	task automatic sender_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Both thresholds are written in one burst with valid held high.
	task automatic program_thresholds(logic [QUAL_W-1:0] min_value,
			logic [QUAL_W-1:0] sync_value);
		cfg_reg_t          regs[2];
		logic [QUAL_W-1:0] values[2];
		regs   = '{REG_MIN_QUALITY, REG_SYNC_QUALITY};
		values = '{min_value, sync_value};
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= values[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_register(regs[i], values[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Waits until every due result has been seen, then lets a reading that
	// produces nothing run out of the datapath.
	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hand-picked readings under the reset thresholds (90 and 99): single
	// sensors at the position extremes, both sensors at full quality, the
	// sync level met exactly, quality exactly at the threshold, zero weight,
	// no elapsed time, a timestamp wrapping past the top, a timestamp going
	// backwards, out-of-range qualities and headings, and a negative average
	// that has to truncate toward zero.
	task automatic directed_readings();
		send_reading(make_reading(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_reading(make_reading(32767, -32768, 35999, 100, 0, 0, 0, 0, 1000));
		send_reading(make_reading(0, 0, 0, 89, -32768, 32767, 0, 100, 1000));
		send_reading(make_reading(32767, -32768, 35999, 100, -32768, 32767, 0, 100, 1001));
		send_reading(make_reading(-1, 1, 18000, 99, 1, -1, 17999, 99, 1001));
		sender_gap(3);
		send_reading(make_reading(100, 200, 300, 90, 400, 500, 600, 95, 1500));
		send_reading(make_reading(5, 5, 5, 90, 5, 5, 5, 90, 1600));
		send_reading(make_reading(-7, -7, 35999, 98, 0, 0, 1, 91, 32'hFFFF_FFFF));
		send_reading(make_reading(12345, -12345, 100, 100, -12345, 12345, 200, 94, 5));
		send_reading(make_reading(0, 0, 0, 100, 0, 0, 0, 100, 3));
		send_reading(make_reading(-32768, -32768, 65535, 127, 32767, 32767, 65535, 127, 4));
		send_reading(make_reading(-7, 7, 1, 127, 0, 0, 0, 100, 4));
		in_valid <= 1'b0;
	endtask

	// Result side: checks every accepted transaction, stalls in random bursts
	// with calm stretches between them, and once holds off for a long spell
	// so that the block fills up and has to stall its input.
	initial begin : result_sink
		fused_t got;
		int     burst_left;
		int     calm_left;
		int     hold_left;
		bit     held;
		burst_left = 0;
		calm_left  = 0;
		hold_left  = 0;
		held       = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{fused_x, fused_y, fused_heading, vel_x, vel_y, total_weight,
					sample_time, sync_heading};
				sb.check_result(got);
				if (!held && sb.results_seen == HOLD_AFTER_RESULTS) begin
					held      = 1'b1;
					hold_left = LONG_HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (calm_left > 0 || quiet_tail) begin
				if (calm_left > 0) calm_left--;
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						burst_left = $urandom_range(1, 13) - 1;
						out_stall <= 1'b1;
					end
					1: begin
						calm_left = $urandom_range(100, 600);
						out_stall <= 1'b0;
					end
					default: begin
						out_stall <= 1'b0;
					end
				endcase
			end
		end
	end

	// Stimulus: reset, the directed readings, then phases of random readings,
	// each under its own pair of thresholds. Phase zero keeps the reset
	// values; the others cover both extremes, thresholds above the quality
	// range, a mid setting and a random one. The sender drains the block
	// before every threshold change.
	initial begin : stimulus
		logic [QUAL_W-1:0] min_value;
		logic [QUAL_W-1:0] sync_value;
		bit                sender_idles;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_MIN_QUALITY;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		left_x        <= '0;
		left_y        <= '0;
		left_heading  <= '0;
		left_quality  <= '0;
		right_x       <= '0;
		right_y       <= '0;
		right_heading <= '0;
		right_quality <= '0;
		reading_time  <= '0;
		quiet_tail    <= 1'b0;
		stamp          = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_readings();
		wait_idle();

		for (int phase = 0; phase <= LAST_PHASE; phase++) begin
			case (phase)
				1: begin min_value = 7'd0;   sync_value = 7'd0;   end
				2: begin min_value = 7'd100; sync_value = 7'd100; end
				3: begin min_value = 7'd110; sync_value = 7'd127; end
				4: begin min_value = 7'd45;  sync_value = 7'd70;  end
				default: begin
					min_value  = QUAL_W'($urandom_range(0, 100));
					sync_value = QUAL_W'($urandom_range(0, 100));
				end
			endcase
			if (phase > 0) begin
				program_thresholds(min_value, sync_value);
			end
			// The sender runs flat out through phase two and the last phase.
			sender_idles = (phase != 2) && (phase != LAST_PHASE);
			if (phase == LAST_PHASE) begin
				quiet_tail <= 1'b1;
			end
			repeat (READINGS_PER_PHASE) begin
				send_reading(random_reading());
				if (sender_idles && $urandom_range(0, 3) == 0) begin
					sender_gap($urandom_range(1, 13));
				end
			end
			in_valid <= 1'b0;
			wait_idle();
		end

		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
